// File: design/ptb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

    // Table geometry
    localparam int NUM_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W      = 4;
    localparam int DATA_W      = 32;

    // Input item modes
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_KILL   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_CREATED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_KILLED  = 2'd2;
    localparam logic [1:0] KIND_EXPIRY  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_KILL,
        ST_TICK,
        ST_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CREATE,
        OP_KILL,
        OP_DEC,
        OP_RELOAD
    } tbl_op_t;

    // Command from sequencer to table
    typedef struct packed {
        tbl_op_t             op;
        logic [IDX_W-1:0]    idx;
        logic [SLOT_W-1:0]   slot;
        logic [DATA_W-1:0]   timeout;
        logic [DATA_W-1:0]   tag;
    } tbl_cmd_t;

    // Table read-back at the walked slot
    typedef struct packed {
        logic                in_use;
        logic                zero;
        logic [DATA_W-1:0]   tag;
    } tbl_rd_t;

    // Result pushed into the output register
    typedef struct packed {
        logic                valid;
        logic [1:0]          kind;
        logic [SLOT_W-1:0]   slot;
        logic [DATA_W-1:0]   tag;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

// File: design/ptb_table.sv
`timescale 1ns / 1ps
`default_nettype none

module ptb_table (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ptb_pkg::tbl_cmd_t cmd,
    output ptb_pkg::tbl_rd_t       rd
);

    logic [ptb_pkg::NUM_TIMERS-1:0] in_use_reg;
    logic [ptb_pkg::DATA_W-1:0]     reload_reg    [ptb_pkg::NUM_TIMERS];
    logic [ptb_pkg::DATA_W-1:0]     remaining_reg [ptb_pkg::NUM_TIMERS];
    logic [ptb_pkg::DATA_W-1:0]     tag_reg       [ptb_pkg::NUM_TIMERS];
    logic [ptb_pkg::DATA_W-1:0]     rem_cur;
    logic                           kill_in_range;

    // Shared countdown unit reads the walked slot
    assign rem_cur       = remaining_reg[cmd.idx];
    assign rd.in_use     = in_use_reg[cmd.idx];
    assign rd.zero       = (rem_cur == '0);
    assign rd.tag        = tag_reg[cmd.idx];
    assign kill_in_range = ({1'b0, cmd.slot} < (ptb_pkg::SLOT_W + 1)'(ptb_pkg::NUM_TIMERS))
                           || (ptb_pkg::NUM_TIMERS > 16);

    // Track occupied slots
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else begin
            case (cmd.op)
                ptb_pkg::OP_CREATE: in_use_reg[cmd.idx] <= 1'b1;
                ptb_pkg::OP_KILL: begin
                    if (kill_in_range) begin
                        in_use_reg[ptb_pkg::IDX_W'(cmd.slot)] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Load, count down or reload the slot data
    always_ff @(posedge aclk) begin
        case (cmd.op)
            ptb_pkg::OP_CREATE: begin
                reload_reg[cmd.idx]    <= cmd.timeout;
                remaining_reg[cmd.idx] <= cmd.timeout;
                tag_reg[cmd.idx]       <= cmd.tag;
            end
            ptb_pkg::OP_DEC:    remaining_reg[cmd.idx] <= rem_cur - ptb_pkg::DATA_W'(1);
            ptb_pkg::OP_RELOAD: remaining_reg[cmd.idx] <= reload_reg[cmd.idx];
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: design/ptb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ptb_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_mode,
    input  wire logic [ptb_pkg::SLOT_W-1:0] s_slot,
    input  wire logic [ptb_pkg::DATA_W-1:0] s_timeout,
    input  wire logic [ptb_pkg::DATA_W-1:0] s_tag,
    input  wire logic                       out_free,
    input  wire ptb_pkg::tbl_rd_t           tbl_rd,
    output ptb_pkg::tbl_cmd_t               tbl_cmd,
    output ptb_pkg::res_t                   push
);

    ptb_pkg::state_t                state_reg, state_next;
    logic [ptb_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [ptb_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [ptb_pkg::DATA_W-1:0]     timeout_reg, timeout_next;
    logic [ptb_pkg::DATA_W-1:0]     tag_reg, tag_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [ptb_pkg::SLOT_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [ptb_pkg::DATA_W-1:0]     pend_tag_reg, pend_tag_next;
    logic [ptb_pkg::CNT_W-1:0]      cnt_reg, cnt_next;

    logic accept;
    logic last_idx;
    logic expire;
    logic capture;
    logic tick_go;

    assign s_ready  = (state_reg == ptb_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign last_idx = (idx_reg == ptb_pkg::IDX_W'(ptb_pkg::NUM_TIMERS - 1));
    assign expire   = tbl_rd.in_use && tbl_rd.zero;
    assign capture  = (cnt_reg < ptb_pkg::CNT_W'(ptb_pkg::MAX_RESULTS));
    // Stall only when a held expiry must leave before a new one is held
    assign tick_go  = !(expire && capture && pend_valid_reg && !out_free);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptb_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        ptb_pkg::MODE_CREATE: state_next = ptb_pkg::ST_CREATE;
                        ptb_pkg::MODE_KILL:   state_next = ptb_pkg::ST_KILL;
                        ptb_pkg::MODE_TICK:   state_next = ptb_pkg::ST_TICK;
                        default:              state_next = ptb_pkg::ST_IDLE;
                    endcase
                end
            end
            ptb_pkg::ST_CREATE,
            ptb_pkg::ST_KILL: begin
                if (push.valid) begin
                    state_next = ptb_pkg::ST_IDLE;
                end
            end
            ptb_pkg::ST_TICK: begin
                if (tick_go && last_idx) begin
                    state_next = ptb_pkg::ST_FLUSH;
                end
            end
            ptb_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ptb_pkg::ST_IDLE;
                end
            end
            default: state_next = ptb_pkg::ST_IDLE;
        endcase
    end

    // Table commands and result pushes
    always_comb begin
        tbl_cmd.op      = ptb_pkg::OP_NONE;
        tbl_cmd.idx     = idx_reg;
        tbl_cmd.slot    = slot_reg;
        tbl_cmd.timeout = timeout_reg;
        tbl_cmd.tag     = tag_reg;
        push            = '0;
        unique case (state_reg)
            ptb_pkg::ST_CREATE: begin
                if (!tbl_rd.in_use) begin
                    if (out_free) begin
                        tbl_cmd.op = ptb_pkg::OP_CREATE;
                        push.valid = 1'b1;
                        push.kind  = ptb_pkg::KIND_CREATED;
                        push.slot  = ptb_pkg::SLOT_W'(idx_reg);
                        push.last  = 1'b1;
                    end
                end else if (last_idx && out_free) begin
                    push.valid = 1'b1;
                    push.kind  = ptb_pkg::KIND_FULL;
                    push.last  = 1'b1;
                end
            end
            ptb_pkg::ST_KILL: begin
                if (out_free) begin
                    tbl_cmd.op = ptb_pkg::OP_KILL;
                    push.valid = 1'b1;
                    push.kind  = ptb_pkg::KIND_KILLED;
                    push.slot  = slot_reg;
                    push.last  = 1'b1;
                end
            end
            ptb_pkg::ST_TICK: begin
                if (tbl_rd.in_use && !tbl_rd.zero) begin
                    tbl_cmd.op = ptb_pkg::OP_DEC;
                end else if (expire && tick_go) begin
                    tbl_cmd.op = ptb_pkg::OP_RELOAD;
                    // Release the held expiry, it is not the final one
                    if (capture && pend_valid_reg) begin
                        push.valid = 1'b1;
                        push.kind  = ptb_pkg::KIND_EXPIRY;
                        push.slot  = pend_slot_reg;
                        push.tag   = pend_tag_reg;
                    end
                end
            end
            ptb_pkg::ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    push.valid = 1'b1;
                    push.kind  = ptb_pkg::KIND_EXPIRY;
                    push.slot  = pend_slot_reg;
                    push.tag   = pend_tag_reg;
                    push.last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Walk index, latched item and held expiry
    always_comb begin
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        timeout_next    = timeout_reg;
        tag_next        = tag_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        cnt_next        = cnt_reg;
        if (accept) begin
            idx_next        = '0;
            slot_next       = s_slot;
            timeout_next    = s_timeout;
            tag_next        = s_tag;
            pend_valid_next = 1'b0;
            cnt_next        = '0;
        end else if (state_reg == ptb_pkg::ST_CREATE) begin
            if (tbl_rd.in_use && !last_idx) begin
                idx_next = idx_reg + ptb_pkg::IDX_W'(1);
            end
        end else if (state_reg == ptb_pkg::ST_TICK) begin
            if (tick_go) begin
                idx_next = idx_reg + ptb_pkg::IDX_W'(1);
                if (expire && capture) begin
                    pend_valid_next = 1'b1;
                    pend_slot_next  = ptb_pkg::SLOT_W'(idx_reg);
                    pend_tag_next   = tbl_rd.tag;
                    cnt_next        = cnt_reg + ptb_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ptb_pkg::ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        timeout_reg   <= timeout_next;
        tag_reg       <= tag_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
    end

    // A push never lands on an occupied output register
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> out_free)
        else $error("result pushed while output register busy");

    // Reported expiries stay within the limit
    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= ptb_pkg::CNT_W'(ptb_pkg::MAX_RESULTS))
        else $error("expiry count beyond limit");

    // The final result of an item returns the sequencer to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid && push.last |=> state_reg == ptb_pkg::ST_IDLE)
        else $error("sequencer busy after final result");

    // A create only claims a free slot
    a_create_free: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_cmd.op == ptb_pkg::OP_CREATE |-> !tbl_rd.in_use)
        else $error("create claimed an occupied slot");

endmodule

`default_nettype wire

// File: design/periodic_timer_bank_top.sv
// Periodic timer bank: NUM_TIMERS countdown slots walked by one shared countdown unit.
// Kill: one KILLED result; create: lowest-slot scan, giving CREATED or FULL.
// Tick: walks every slot, then a flush state releases the final held expiry.
// One item at a time, taken in idle; a result waiting in the output register stalls
// create, kill and flush, and stalls the walk only when a new expiry must be held.
// Reset (aresetn low, synchronous) frees every slot and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_bank_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_mode,
    input  wire logic [ptb_pkg::SLOT_W-1:0] s_slot,
    input  wire logic [ptb_pkg::DATA_W-1:0] s_timeout,
    input  wire logic [ptb_pkg::DATA_W-1:0] s_tag,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [1:0]                      m_kind,
    output logic [ptb_pkg::SLOT_W-1:0]      m_slot_out,
    output logic [ptb_pkg::DATA_W-1:0]      m_tag_out,
    output logic                            m_last
);

    ptb_pkg::tbl_cmd_t              tbl_cmd;
    ptb_pkg::tbl_rd_t               tbl_rd;
    ptb_pkg::res_t                  push;
    logic                           out_free;
    logic                           m_valid_reg;
    logic [1:0]                     m_kind_reg;
    logic [ptb_pkg::SLOT_W-1:0]     m_slot_reg;
    logic [ptb_pkg::DATA_W-1:0]     m_tag_reg;
    logic                           m_last_reg;

    assign out_free = !m_valid_reg || m_ready;

    ptb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_slot    (s_slot),
        .s_timeout (s_timeout),
        .s_tag     (s_tag),
        .out_free  (out_free),
        .tbl_rd    (tbl_rd),
        .tbl_cmd   (tbl_cmd),
        .push      (push)
    );

    ptb_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tbl_cmd),
        .rd      (tbl_rd)
    );

    // Output register valid: load on push, drop on take
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            m_kind_reg <= push.kind;
            m_slot_reg <= push.slot;
            m_tag_reg  <= push.tag;
            m_last_reg <= push.last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_slot_out = m_slot_reg;
    assign m_tag_out  = m_tag_reg;
    assign m_last     = m_last_reg;

endmodule

`default_nettype wire
